>>> rtl/json_string_unescape_top_defines.svh
// Assertion macros for the checks in the top-level design file.
`ifndef JSON_STRING_UNESCAPE_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jsu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jsu: next-cycle check failed");

`endif

>>> rtl/jsu_pkg.sv
package jsu_pkg;

    typedef enum logic [2:0] {
        ST_BUSY   = 3'd0,
        ST_DONE   = 3'd1,
        ST_UNTERM = 3'd2,
        ST_BADESC = 3'd3,
        ST_SHORT  = 3'd4,
        ST_BADHEX = 3'd5,
        ST_CTRL   = 3'd6
    } t_status;

    // Results caused by one input item: up to three decoded bytes.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        t_status         st;
    } t_run;

endpackage

>>> rtl/jsu_if.sv
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last_of_run;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input status,
                    input last_of_run, output ready);
endinterface

>>> rtl/jsu_decode.sv
module jsu_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic [7:0]    i_byte,
    input  logic          i_eot,
    output jsu_pkg::t_run o_run
);

    typedef enum logic [3:0] {
        MODE_WAIT = 4'b0001,
        MODE_TEXT = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_HEX  = 4'b1000
    } t_mode;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    t_mode       r_mode,    n_mode;
    logic [15:0] r_hex_val, n_hex_val;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic        r_hex_bad, n_hex_bad;

    logic        dig_ok;
    logic [3:0]  dig;
    logic [15:0] cp;
    jsu_pkg::t_run run;

    always_comb begin
        dig_ok = 1'b1;
        dig    = 4'h0;
        if (i_byte inside {[8'h30:8'h39]}) begin
            dig = i_byte[3:0];
        end else if (i_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            dig = i_byte[3:0] + 4'd9;
        end else begin
            dig_ok = 1'b0;
        end
    end

    assign cp = {r_hex_val[11:0], dig};

    always_comb begin
        n_mode    = r_mode;
        n_hex_val = r_hex_val;
        n_hex_cnt = r_hex_cnt;
        n_hex_bad = r_hex_bad;
        run        = '0;
        run.st     = jsu_pkg::ST_BUSY;

        case (r_mode)
            MODE_TEXT: begin
                if (i_byte == CH_QUOTE) begin
                    run.st = jsu_pkg::ST_DONE;
                end else if (i_byte == CH_BSL) begin
                    if (i_eot) run.st = jsu_pkg::ST_UNTERM;
                    else       n_mode = MODE_ESC;
                end else if (i_byte < CH_SPACE) begin
                    run.st = jsu_pkg::ST_CTRL;
                end else begin
                    run.bytes[0] = i_byte;
                    run.nbytes   = 2'd1;
                    if (i_eot) run.st = jsu_pkg::ST_UNTERM;
                end
            end
            MODE_ESC: begin
                case (i_byte)
                    CH_QUOTE, CH_BSL, CH_SLASH: begin
                        run.bytes[0] = i_byte;
                        run.nbytes   = 2'd1;
                    end
                    CH_B: begin run.bytes[0] = 8'h08; run.nbytes = 2'd1; end
                    CH_F: begin run.bytes[0] = 8'h0C; run.nbytes = 2'd1; end
                    CH_N: begin run.bytes[0] = 8'h0A; run.nbytes = 2'd1; end
                    CH_R: begin run.bytes[0] = 8'h0D; run.nbytes = 2'd1; end
                    CH_T: begin run.bytes[0] = 8'h09; run.nbytes = 2'd1; end
                    CH_U: begin
                        if (i_eot) begin
                            run.st = jsu_pkg::ST_SHORT;
                        end else begin
                            n_hex_val = '0;
                            n_hex_cnt = '0;
                            n_hex_bad = 1'b0;
                            n_mode    = MODE_HEX;
                        end
                    end
                    default: run.st = jsu_pkg::ST_BADESC;
                endcase
                if (run.nbytes != 2'd0) begin
                    n_mode = MODE_TEXT;
                    if (i_eot) run.st = jsu_pkg::ST_UNTERM;
                end
            end
            MODE_HEX: begin
                n_hex_val = cp;
                n_hex_bad = r_hex_bad | ~dig_ok;
                if (r_hex_cnt == 2'd3) begin
                    if (n_hex_bad) begin
                        run.st = jsu_pkg::ST_BADHEX;
                    end else begin
                        if (cp < 16'h0080) begin
                            run.bytes[0] = cp[7:0];
                            run.nbytes   = 2'd1;
                        end else if (cp < 16'h0800) begin
                            run.bytes[0] = {3'b110, cp[10:6]};
                            run.bytes[1] = {2'b10, cp[5:0]};
                            run.nbytes   = 2'd2;
                        end else begin
                            run.bytes[0] = {4'b1110, cp[15:12]};
                            run.bytes[1] = {2'b10, cp[11:6]};
                            run.bytes[2] = {2'b10, cp[5:0]};
                            run.nbytes   = 2'd3;
                        end
                        if (i_eot) run.st = jsu_pkg::ST_UNTERM;
                    end
                    n_hex_val = '0;
                    n_hex_cnt = '0;
                    n_hex_bad = 1'b0;
                    n_mode    = MODE_TEXT;
                end else begin
                    n_hex_cnt = r_hex_cnt + 2'd1;
                    if (i_eot) run.st = jsu_pkg::ST_SHORT;
                end
            end
            default: begin
                // opening quote: dropped unchecked
                if (i_eot) run.st = jsu_pkg::ST_UNTERM;
                else       n_mode = MODE_TEXT;
            end
        endcase

        if (run.st != jsu_pkg::ST_BUSY) begin
            n_mode    = MODE_WAIT;
            n_hex_val = '0;
            n_hex_cnt = '0;
            n_hex_bad = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_WAIT;
            r_hex_val <= '0;
            r_hex_cnt <= '0;
            r_hex_bad <= 1'b0;
        end else if (i_adv) begin
            r_mode    <= n_mode;
            r_hex_val <= n_hex_val;
            r_hex_cnt <= n_hex_cnt;
            r_hex_bad <= n_hex_bad;
        end
    end

    assign o_run = run;

endmodule

>>> rtl/jsu_emit.sv
module jsu_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  jsu_pkg::t_run i_run,
    output logic          o_free,
    jsu_out_if.source     o_out
);

    jsu_pkg::t_run r_run;
    logic          r_full;
    logic [1:0]    r_idx;
    logic [1:0]    n_idx;
    logic          has_byte;
    logic          last;
    logic          take;
    logic [7:0]    sel_byte;

    assign has_byte = (r_idx < r_run.nbytes);
    // a run with no decoded byte still gives one result
    assign last     = (r_run.nbytes == 2'd0) || (r_idx == r_run.nbytes - 2'd1);
    assign take     = r_full && o_out.ready;
    assign o_free   = !r_full || (take && last);
    assign n_idx    = r_idx + 2'd1;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = r_run.bytes[0];
            2'd1:    sel_byte = r_run.bytes[1];
            2'd2:    sel_byte = r_run.bytes[2];
            default: sel_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= '0;
        end else if (i_load && o_free) begin
            r_full <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last) r_full <= 1'b0;
            else      r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) r_run <= i_run;
    end

    assign o_out.valid       = r_full;
    assign o_out.out_byte    = has_byte ? sel_byte : 8'h00;
    assign o_out.byte_valid  = has_byte;
    assign o_out.status      = last ? r_run.st : jsu_pkg::ST_BUSY;
    assign o_out.last_of_run = last;

endmodule

>>> rtl/json_string_unescape_top.sv
// JSON string unescaper.
// i_in takes the raw bytes of a string literal, one item per byte, with
// end_of_text set on the final byte of the text. The first byte is the
// opening quote. o_out gives one item per decoded UTF-8 byte (1 to 3 per
// input byte) or a single item with byte_valid low when the byte decodes
// to nothing; last_of_run marks the final item for each input byte and
// carries the status (done, unterminated or one of the error codes).
// After any nonzero status the next byte opens a new string.
// An accepted input byte passes through the input register, then the
// result register, before it reaches the output. Throughput: one input
// byte per cycle while each decodes to at most one byte and o_out.ready
// is high; a \u escape that gives 2 or 3 bytes holds the input until the
// result register, which hands out one byte per cycle, has sent them all.
// Reset (synchronous, active low) empties both registers and returns the
// decoder to waiting for an opening quote. When o_out.ready is low the
// result register holds its item; an empty input register takes one more
// input byte, then i_in.ready drops until the output drains.
`include "json_string_unescape_top_defines.svh"

module json_string_unescape_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_eot;
    logic          emit_free;
    logic          adv;
    jsu_pkg::t_run run;

    assign adv         = r_in_valid && emit_free;
    assign i_in.ready  = !r_in_valid || emit_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_eot  <= i_in.end_of_text;
        end
    end

    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_eot   (r_in_eot),
        .o_run   (run)
    );

    jsu_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_run   (run),
        .o_free  (emit_free),
        .o_out   (o_out)
    );

    `JSU_ASSERT_NOW(a_status_on_last, i_clk, i_rst_n,
        o_out.valid && (o_out.status != jsu_pkg::ST_BUSY), o_out.last_of_run)
    `JSU_ASSERT_NOW(a_empty_run_single, i_clk, i_rst_n,
        o_out.valid && !o_out.byte_valid, o_out.last_of_run)
    `JSU_ASSERT_NEXT(a_accept_fills_input, i_clk, i_rst_n,
        i_in.valid && i_in.ready, r_in_valid)
    `JSU_ASSERT_NEXT(a_advance_fills_output, i_clk, i_rst_n,
        adv, o_out.valid)

endmodule

>>> tb/tb_top.sv
module tb_top;
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] ASCII_BS   = 8'h08;
    localparam logic [7:0] ASCII_FF   = 8'h0C;
    localparam logic [7:0] ASCII_LF   = 8'h0A;
    localparam logic [7:0] ASCII_CR   = 8'h0D;
    localparam logic [7:0] ASCII_TAB  = 8'h09;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         SETTLE_CYCLES = 16;

    typedef enum logic [1:0] {
        SCAN_WAIT,
        SCAN_TEXT,
        SCAN_ESC,
        SCAN_HEX
    } t_scan;

    typedef struct {
        logic [7:0] data;
        logic       vld;
        t_status    st;
        logic       last;
    } t_decoded;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jsu_in_if  in_if();
    jsu_out_if out_if();

    json_string_unescape_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // decoder state as the block should hold it
    t_scan       scan = SCAN_WAIT;
    logic [15:0] hex_acc = '0;
    int          hex_cnt = 0;
    bit          hex_bad = 1'b0;

    t_decoded decoded_q[$];
    int       n_err = 0;
    int       n_offered = 0;
    bit       in_gaps = 1'b1;
    bit       out_stalls = 1'b1;
    int       quiet = 0;

    function automatic int nibble_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
        if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
        if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function void clear_hex();
        hex_acc = '0;
        hex_cnt = 0;
        hex_bad = 1'b0;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic eot);
        logic [7:0]  emit [3];
        int          n;
        int          cnt;
        int          d;
        logic [15:0] cp;
        t_status     st;
        t_decoded    r;
        n  = 0;
        st = ST_BUSY;
        case (scan)
            SCAN_TEXT: begin
                if (b == CH_QUOTE) begin
                    st = ST_DONE;
                end else if (b == CH_BSLASH) begin
                    if (eot) st = ST_UNTERM;
                    else scan = SCAN_ESC;
                end else if (b < CTRL_LIMIT) begin
                    st = ST_CTRL;
                end else begin
                    emit[0] = b;
                    n = 1;
                    if (eot) st = ST_UNTERM;
                end
            end
            SCAN_ESC: begin
                case (b)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: begin emit[0] = b;         n = 1; end
                    CH_B:                          begin emit[0] = ASCII_BS;  n = 1; end
                    CH_F:                          begin emit[0] = ASCII_FF;  n = 1; end
                    CH_N:                          begin emit[0] = ASCII_LF;  n = 1; end
                    CH_R:                          begin emit[0] = ASCII_CR;  n = 1; end
                    CH_T:                          begin emit[0] = ASCII_TAB; n = 1; end
                    CH_U: begin
                        if (eot) begin
                            st = ST_SHORT;
                        end else begin
                            clear_hex();
                            scan = SCAN_HEX;
                        end
                    end
                    default: st = ST_BADESC;
                endcase
                if (n > 0) begin
                    scan = SCAN_TEXT;
                    if (eot) st = ST_UNTERM;
                end
            end
            SCAN_HEX: begin
                // non-hex bytes still count as a digit (value 0)
                d = nibble_of(b);
                if (d < 0) begin
                    hex_bad = 1'b1;
                    d = 0;
                end
                hex_acc = {hex_acc[11:0], 4'(d)};
                hex_cnt++;
                if (hex_cnt >= 4) begin
                    if (hex_bad) begin
                        st = ST_BADHEX;
                    end else begin
                        cp = hex_acc;
                        if (cp < 16'h0080) begin
                            emit[0] = cp[7:0];
                            n = 1;
                        end else if (cp < 16'h0800) begin
                            emit[0] = 8'hC0 | {3'b000, cp[10:6]};
                            emit[1] = 8'h80 | {2'b00, cp[5:0]};
                            n = 2;
                        end else begin
                            emit[0] = 8'hE0 | {4'h0, cp[15:12]};
                            emit[1] = 8'h80 | {2'b00, cp[11:6]};
                            emit[2] = 8'h80 | {2'b00, cp[5:0]};
                            n = 3;
                        end
                        if (eot) st = ST_UNTERM;
                    end
                    clear_hex();
                    scan = SCAN_TEXT;
                end else if (eot) begin
                    st = ST_SHORT;
                end
            end
            default: begin
                // opening quote, not checked
                if (eot) st = ST_UNTERM;
                else scan = SCAN_TEXT;
            end
        endcase
        if (st != ST_BUSY) begin
            scan = SCAN_WAIT;
            clear_hex();
        end
        cnt = (n > 0) ? n : 1;
        for (int k = 0; k < cnt; k++) begin
            r.data = (k < n) ? emit[k] : 8'h00;
            r.vld  = (k < n);
            r.last = (k == cnt - 1);
            r.st   = r.last ? st : ST_BUSY;
            decoded_q = {decoded_q, r};
        end
    endtask

    // input side: every accepted item updates the prediction
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            decode_byte(in_if.in_byte, in_if.end_of_text);
    end

    always @(posedge i_clk) begin : check_output
        t_decoded want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected output item: out_byte %02h byte_valid %0d status %0d",
                       out_if.out_byte, out_if.byte_valid, out_if.status);
                n_err++;
            end else begin
                want = decoded_q.pop_front();
                if (out_if.out_byte !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, out_if.out_byte);
                    n_err++;
                end
                if (out_if.byte_valid !== want.vld) begin
                    $error("byte_valid: expected %0d, got %0d", want.vld, out_if.byte_valid);
                    n_err++;
                end
                if (out_if.status !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, out_if.status);
                    n_err++;
                end
                if (out_if.last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, out_if.last_of_run);
                    n_err++;
                end
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_stalls && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (in_gaps && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.in_byte     <= b;
        in_if.end_of_text <= eot;
        do @(posedge i_clk); while (!in_if.ready);
        n_offered++;
    endtask

    task automatic send_text(input string s, input logic eot_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_last && (i == s.len() - 1));
    endtask

    // One string literal. Broken ones always end with end_of_text so the
    // decoder is back at the opening quote for the next string.
    task automatic send_random_string(input bit clean);
        logic [7:0]  text[$];
        logic [7:0]  b;
        logic [15:0] cp;
        logic        eot_last;
        int          n_el;
        int          cut;
        text = {text, (($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : CH_QUOTE)};
        n_el = $urandom_range(0, 8);
        for (int e = 0; e < n_el; e++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    b = 8'($urandom_range(32'h20, 32'hFF));
                    if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h7E;
                    text = {text, b};
                end
                5, 6: begin
                    text = {text, CH_BSLASH};
                    case ($urandom_range(0, 7))
                        0: text = {text, CH_QUOTE};
                        1: text = {text, CH_BSLASH};
                        2: text = {text, CH_SLASH};
                        3: text = {text, CH_B};
                        4: text = {text, CH_F};
                        5: text = {text, CH_N};
                        6: text = {text, CH_R};
                        default: text = {text, CH_T};
                    endcase
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: cp = 16'($urandom_range(0, 32'h7F));
                        1: cp = 16'($urandom_range(32'h80, 32'h7FF));
                        default: cp = 16'($urandom_range(32'h800, 32'hFFFF));
                    endcase
                    if ($urandom_range(0, 7) == 0) begin
                        case ($urandom_range(0, 5))
                            0: cp = 16'h0000;
                            1: cp = 16'h007F;
                            2: cp = 16'h0080;
                            3: cp = 16'h07FF;
                            4: cp = 16'h0800;
                            default: cp = 16'hFFFF;
                        endcase
                    end
                    text = {text, CH_BSLASH};
                    text = {text, CH_U};
                    for (int k = 3; k >= 0; k--) begin
                        b = hex_ascii(cp[k*4 +: 4], $urandom_range(0, 1));
                        if (!clean && $urandom_range(0, 5) == 0) b = 8'($urandom_range(0, 255));
                        text = {text, b};
                    end
                end
            endcase
        end
        text = {text, CH_QUOTE};
        eot_last = clean ? 1'($urandom_range(0, 1)) : 1'b1;
        if (!clean) begin
            case ($urandom_range(0, 2))
                0: begin
                    cut = $urandom_range(1, text.size() - 1);
                    text = text[0:cut-1];
                end
                1: text[$urandom_range(1, text.size() - 1)] = 8'($urandom_range(0, 255));
                default: text[$urandom_range(1, text.size() - 1)] = 8'($urandom_range(0, 31));
            endcase
        end
        for (int i = 0; i < text.size(); i++)
            send_byte(text[i], eot_last && (i == text.size() - 1));
    endtask

    task automatic test_directed();
        // raw 0xFF, code point 0, 0xFFFF in mixed case, \/ and a closing quote
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("\\u0000\\uFfFf\\/\"", 1'b0);
        // unchecked opening byte, then an unescaped 0x00
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("\"\\x", 1'b0);
        // a quote taken as a hex digit, then a bad digit at the fourth place
        send_text("\"\\u\"12G", 1'b0);
        // short unicode wins over a bad digit already seen
        send_text("\"\\uG1", 1'b1);
        send_text("\"", 1'b1);
    endtask

    task automatic test_random_text(input int upto);
        while (n_offered < upto)
            send_random_string($urandom_range(0, 4) != 0);
    endtask

    task automatic test_drain_pause();
        send_random_string(1'b1);
        in_if.valid <= 1'b0;
        // wait so the last accepted item is already predicted
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_full_rate(input int upto);
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
        test_random_text(upto);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.in_byte     <= 8'h00;
        in_if.end_of_text <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_text(220);
        test_drain_pause();
        test_random_text(320);
        test_full_rate(410);
        in_if.valid <= 1'b0;
        @(posedge i_clk);

        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_err == 0 && decoded_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_if.sv
rtl/jsu_decode.sv
rtl/jsu_emit.sv
rtl/json_string_unescape_top.sv
tb/tb_top.sv
